// File: src/tcc_pkg.sv
// shared types and constants of the interval timer counter channel
package tcc_pkg;

  // item kinds carried in the request tuser
  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_CTRL  = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_GATE  = 3'd4
  } opcode_e;

  // byte access patterns of the control word
  localparam logic [1:0] ACC_LATCH = 2'd0;
  localparam logic [1:0] ACC_LOW   = 2'd1;
  localparam logic [1:0] ACC_HIGH  = 2'd2;
  localparam logic [1:0] ACC_WORD  = 2'd3;

  // counting modes that are implemented
  localparam logic [2:0] MODE_ONESHOT = 3'd1;
  localparam logic [2:0] MODE_STROBE  = 3'd4;

  // counter select code that means read-back
  localparam logic [1:0] SEL_READBACK = 2'd3;

  localparam logic [1:0] CHSEL_RESET = 2'd2;

  // one accepted request
  typedef struct packed {
    opcode_e    opcode;
    logic [7:0] data_byte;
    logic       gate_level;
  } item_t;

  // one result
  typedef struct packed {
    logic       out_level;
    logic [7:0] read_byte;
  } res_t;

  // channel state
  typedef struct packed {
    logic [15:0] reload_value;
    logic [15:0] current_count;
    logic [15:0] latched_count;
    logic        latch_valid;
    logic        write_high_next;
    logic        read_high_next;
    logic [1:0]  access_mode;
    logic [2:0]  count_mode;
    logic        output_pin;
    logic        gate_previous;
    logic        load_pending;
    logic        counting;
    logic        strobe_armed;
  } chan_state_t;

  localparam chan_state_t STATE_RESET = '{
    reload_value:    16'h0000,
    current_count:   16'h0000,
    latched_count:   16'h0000,
    latch_valid:     1'b0,
    write_high_next: 1'b0,
    read_high_next:  1'b0,
    access_mode:     ACC_WORD,
    count_mode:      3'd0,
    output_pin:      1'b1,
    gate_previous:   1'b0,
    load_pending:    1'b0,
    counting:        1'b0,
    strobe_armed:    1'b0
  };

endpackage

// File: src/tcc_chan.sv
// channel state registers and the per-request update logic
module tcc_chan import tcc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       req_i,
  input  item_t      item_i,
  output res_t       res_o
);

  logic [1:0]  chsel_q;
  chan_state_t st_q, st_d;
  logic [15:0] cnt_dec;
  logic [15:0] rd_val;
  logic        rb_hit;
  logic [1:0]  w_sel;
  logic [1:0]  w_rw;
  logic        wr_done;
  logic [7:0]  rd_byte;

  assign cnt_dec = st_q.current_count - 16'd1;
  assign rd_val  = st_q.latch_valid ? st_q.latched_count : st_q.current_count;
  assign w_sel   = item_i.data_byte[7:6];
  assign w_rw    = item_i.data_byte[5:4];

  // read-back hit for this channel's counter bit
  always_comb begin
    unique case (chsel_q)
      2'd0:    rb_hit = item_i.data_byte[1];
      2'd1:    rb_hit = item_i.data_byte[2];
      2'd2:    rb_hit = item_i.data_byte[3];
      default: rb_hit = 1'b0;
    endcase
    rb_hit = rb_hit & ~item_i.data_byte[5];
  end

  // next state and returned byte
  always_comb begin
    st_d    = st_q;
    rd_byte = 8'h00;
    wr_done = 1'b0;
    if (req_i) begin
      unique case (item_i.opcode)
        OP_TICK: begin
          if (st_q.count_mode == MODE_ONESHOT) begin
            if (st_q.load_pending) begin
              st_d.current_count = st_q.reload_value;
              st_d.load_pending  = 1'b0;
              st_d.counting      = 1'b1;
              st_d.output_pin    = 1'b0;
            end else if (st_q.counting) begin
              st_d.current_count = cnt_dec;
              if (cnt_dec == 16'h0000) begin
                st_d.output_pin = 1'b1;
              end
            end
          end else if (st_q.count_mode == MODE_STROBE) begin
            st_d.output_pin = 1'b1;
            if (st_q.load_pending) begin
              st_d.current_count = st_q.reload_value;
              st_d.load_pending  = 1'b0;
              st_d.counting      = 1'b1;
              st_d.strobe_armed  = 1'b1;
            end else if (st_q.counting && st_q.gate_previous) begin
              st_d.current_count = cnt_dec;
              if (cnt_dec == 16'h0000 && st_q.strobe_armed) begin
                st_d.output_pin   = 1'b0;
                st_d.strobe_armed = 1'b0;
              end
            end
          end
        end
        OP_CTRL: begin
          if (w_sel == SEL_READBACK) begin
            if (rb_hit && !st_q.latch_valid) begin
              st_d.latched_count = st_q.current_count;
              st_d.latch_valid   = 1'b1;
            end
          end else if (w_sel == chsel_q) begin
            if (w_rw == ACC_LATCH) begin
              if (!st_q.latch_valid) begin
                st_d.latched_count = st_q.current_count;
                st_d.latch_valid   = 1'b1;
              end
            end else begin
              st_d.access_mode     = w_rw;
              st_d.count_mode      = item_i.data_byte[3:1];
              st_d.output_pin      = 1'b1;
              st_d.counting        = 1'b0;
              st_d.load_pending    = 1'b0;
              st_d.strobe_armed    = 1'b0;
              st_d.latch_valid     = 1'b0;
              st_d.write_high_next = 1'b0;
              st_d.read_high_next  = 1'b0;
            end
          end
        end
        OP_WRITE: begin
          unique case (st_q.access_mode)
            ACC_LOW: begin
              st_d.reload_value = {8'h00, item_i.data_byte};
              wr_done = 1'b1;
            end
            ACC_HIGH: begin
              st_d.reload_value = {item_i.data_byte, 8'h00};
              wr_done = 1'b1;
            end
            ACC_WORD: begin
              if (!st_q.write_high_next) begin
                st_d.reload_value    = {st_q.reload_value[15:8], item_i.data_byte};
                st_d.write_high_next = 1'b1;
              end else begin
                st_d.reload_value    = {item_i.data_byte, st_q.reload_value[7:0]};
                st_d.write_high_next = 1'b0;
                wr_done = 1'b1;
              end
            end
            default: begin
            end
          endcase
          if (wr_done && st_q.count_mode == MODE_STROBE) begin
            st_d.load_pending = 1'b1;
          end
        end
        OP_READ: begin
          unique case (st_q.access_mode)
            ACC_LOW: begin
              rd_byte = rd_val[7:0];
              st_d.latch_valid = 1'b0;
            end
            ACC_HIGH: begin
              rd_byte = rd_val[15:8];
              st_d.latch_valid = 1'b0;
            end
            ACC_WORD: begin
              if (!st_q.read_high_next) begin
                rd_byte = rd_val[7:0];
                st_d.read_high_next = 1'b1;
              end else begin
                rd_byte = rd_val[15:8];
                st_d.read_high_next = 1'b0;
                st_d.latch_valid    = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
        OP_GATE: begin
          if (item_i.gate_level && !st_q.gate_previous &&
              st_q.count_mode == MODE_ONESHOT) begin
            st_d.load_pending = 1'b1;
          end
          st_d.gate_previous = item_i.gate_level;
        end
        default: begin
        end
      endcase
    end
  end

  assign res_o.read_byte = rd_byte;
  assign res_o.out_level = st_d.output_pin;

  // state and channel select registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= STATE_RESET;
      chsel_q <= CHSEL_RESET;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        chsel_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// File: src/tcc_obuf.sv
// result register with a skid stage
module tcc_obuf import tcc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  res_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic push;
  logic pop;

  assign in_ready_o = ~skid_valid_q;
  assign push       = in_valid_i & ~skid_valid_q;
  assign pop        = out_valid_q & out_ready_i;

  // refill the output from the skid first, else from the new request
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push;
        out_d       = in_data_i;
      end
    end else if (push) begin
      skid_valid_d = 1'b1;
      skid_d       = in_data_i;
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: src/interval_timer_counter_channel_core.sv
// Interval timer counter channel: one request accepted per cycle when the
// skid stage is empty; its result goes to the result register, or to the
// skid stage while the result register is held. Sustained throughput is
// one request per cycle while m_axis_tready stays high; the state update
// to the result register is combinational. Asynchronous active-low reset:
// channel in reset state, select two, output and skid stages empty.
module interval_timer_counter_channel_core import tcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // data_byte [7:0], gate_level [8], zero
  input  logic [2:0]  s_axis_tuser,  // opcode [2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // read_byte [7:0], out_level [8], zero
);

  item_t item;
  res_t  res;
  res_t  res_out;
  logic  req;

  assign item.opcode     = opcode_e'(s_axis_tuser);
  assign item.data_byte  = s_axis_tdata[7:0];
  assign item.gate_level = s_axis_tdata[8];
  assign req             = s_axis_tvalid & s_axis_tready;

  // channel state and update
  tcc_chan u_chan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req),
    .item_i      (item),
    .res_o       (res)
  );

  // result buffering
  tcc_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res_out)
  );

  assign m_axis_tdata = {7'd0, res_out.out_level, res_out.read_byte};

`ifndef SYNTHESIS
  // a full skid stage means the result register is also holding a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("skid full while result register empty");

  // every accepted request leaves a pending result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req |=> m_axis_tvalid)
    else $error("accepted request produced no result");

  // only a data read returns a nonzero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req && res.read_byte != 8'h00) |-> (item.opcode == OP_READ))
    else $error("nonzero read byte for a request that is not a read");
`endif

endmodule
